// ===== sv/fss_pkg.sv =====
// Shared types and constants for the stiffness scatter-add block.
// No dependencies; imported by the front, back and top-level modules.
package fss_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD_CONN = 3'd0,
      CMD_LOAD_EQ   = 3'd1,
      CMD_ADD_STIFF = 3'd2,
      CMD_ADD_LOAD  = 3'd3,
      CMD_READ_MAT  = 3'd4,
      CMD_READ_VEC  = 3'd5
   } cmd_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   // Back-end operation codes
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_ACC   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [1:0] REG_DOF = 2'd0;
   localparam logic [1:0] REG_NPE = 2'd1;

endpackage

// ===== sv/fss_front.sv =====
// Front part: table loads and two-step equation lookup for each item.
// Depends on fss_pkg. Produces one decoded operation per item.
module fss_front import fss_pkg::*; #(
   parameter int MAX_NPE   = 8,
   parameter int MAX_DOF   = 3,
   parameter int MAX_ELEMS = 1024,
   parameter int MAX_NODES = 1024,
   parameter int MAX_FREE  = 64,
   parameter int MAX_FIXED = 64,
   parameter int AW        = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   dof_per_node,
   input  logic [3:0]   nodes_per_element,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [2:0]   command,
   input  logic [9:0]   element,
   input  logic [4:0]   local_row,
   input  logic [4:0]   local_col,
   input  logic [2:0]   node_slot,
   input  logic [9:0]   global_node,
   input  logic [1:0]   node_dof,
   input  logic signed [7:0] equation,
   input  logic [63:0]  value,
   input  logic [1:0]   block_select,
   input  logic [5:0]   row_index,
   input  logic [5:0]   col_index,
   output logic         op_valid,
   input  logic         op_stall,
   output op_type       op_kind,
   output logic [1:0]   op_sel,
   output logic [AW-1:0] op_addr,
   output logic [63:0]  op_value,
   output logic [1:0]   op_status
);

   localparam int CW = $clog2(MAX_ELEMS*MAX_NPE);
   localparam int EW = $clog2(MAX_NODES*MAX_DOF);
   localparam int NW = $clog2(MAX_NODES);

   typedef enum logic [2:0] {S_IDLE, S_CONN, S_EQ, S_EMIT, S_OUT} state_type;

   logic [9:0] conn_mem [MAX_ELEMS*MAX_NPE];
   logic [7:0] eq_mem   [MAX_NODES*MAX_DOF];

   state_type   state_ff;
   logic [2:0]  cmd_ff;
   logic [9:0]  elem_ff;
   logic [63:0] val_ff;
   logic [1:0]  blk_ff;
   logic [5:0]  ri_ff, ci_ff;
   logic        bad_ff;
   logic        side_ff;       // 0 row, 1 column
   logic [1:0]  drow_ff, dcol_ff;
   logic [2:0]  srow_ff, scol_ff;
   logic [9:0]  conn_q_ff;
   logic [7:0]  eq_q_ff;
   logic signed [7:0] er_ff, ec_ff;
   logic        ov_ff;
   op_type      ok_ff;
   logic [1:0]  osel_ff, ost_ff;
   logic [AW-1:0] oaddr_ff;

   logic        accept;
   logic        regs_ok;
   logic [5:0]  lim;
   logic [2:0]  sl_r, sl_c;
   logic [1:0]  d_r, d_c;
   logic [8:0]  qr_prod, qc_prod;
   logic [3:0]  qr, qc;
   logic [4:0]  rr, rc;

   assign in_stall = (state_ff != S_IDLE);
   assign accept   = in_valid && !in_stall;
   assign regs_ok  = (dof_per_node != 2'd0) && (32'(dof_per_node) <= MAX_DOF) &&
                     (nodes_per_element != 4'd0) &&
                     (32'(nodes_per_element) <= MAX_NPE);
   assign lim      = 6'(nodes_per_element) * 6'(dof_per_node);

   // Divide by three: multiply by 11/32, exact for indices below 32
   assign qr_prod = 9'(local_row) * 9'd11;
   assign qc_prod = 9'(local_col) * 9'd11;
   assign qr      = qr_prod[8:5];
   assign qc      = qc_prod[8:5];
   assign rr      = local_row - 5'(qr) * 5'd3;
   assign rc      = local_col - 5'(qc) * 5'd3;

   // Split local indices into slot and dof
   always_comb begin
      sl_r = 3'd0; d_r = 2'd0; sl_c = 3'd0; d_c = 2'd0;
      case (dof_per_node)
         2'd1: begin
            sl_r = local_row[2:0]; sl_c = local_col[2:0];
         end
         2'd2: begin
            sl_r = local_row[3:1]; d_r = {1'b0, local_row[0]};
            sl_c = local_col[3:1]; d_c = {1'b0, local_col[0]};
         end
         2'd3: begin
            sl_r = qr[2:0]; d_r = rr[1:0];
            sl_c = qc[2:0]; d_c = rc[1:0];
         end
         default: begin
            sl_r = 3'd0;
         end
      endcase
   end

   // Table writes
   always_ff @(posedge clock) begin
      if (accept && cmd_type'(command) == CMD_LOAD_CONN &&
          32'(element) < MAX_ELEMS && 32'(node_slot) < MAX_NPE &&
          32'(global_node) < MAX_NODES)
         conn_mem[CW'(element*MAX_NPE + node_slot)] <= global_node;
      if (accept && cmd_type'(command) == CMD_LOAD_EQ &&
          32'(global_node) < MAX_NODES && 32'(node_dof) < MAX_DOF &&
          ((equation > 0 && 32'(equation) <= MAX_FREE) ||
           (equation < 0 && -32'(equation) <= MAX_FIXED)))
         eq_mem[EW'(global_node*MAX_DOF + node_dof)] <= equation;
   end

   logic eq_good;
   logic signed [7:0] eqv;
   assign eqv = eq_q_ff;
   assign eq_good = (eqv > 0 && 32'(eqv) <= MAX_FREE) ||
                    (eqv < 0 && -32'(eqv) <= MAX_FIXED);

   // Sequencer: connectivity read, equation read, per side
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= command; elem_ff <= element;
                  val_ff <= value; blk_ff <= block_select;
                  ri_ff <= row_index; ci_ff <= col_index;
                  srow_ff <= sl_r; drow_ff <= d_r; scol_ff <= sl_c; dcol_ff <= d_c;
                  side_ff <= 1'b0;
                  bad_ff <= !regs_ok || 32'(element) >= MAX_ELEMS ||
                            6'(local_row) >= lim ||
                            (cmd_type'(command) == CMD_ADD_STIFF &&
                             6'(local_col) >= lim);
                  if (cmd_type'(command) == CMD_ADD_STIFF ||
                      cmd_type'(command) == CMD_ADD_LOAD)
                     state_ff <= S_CONN;
                  else
                     state_ff <= S_EMIT;
                  conn_q_ff <= conn_mem[CW'(element*MAX_NPE + sl_r)];
               end
            end
            S_CONN: begin
               if (32'(conn_q_ff) >= MAX_NODES) bad_ff <= 1'b1;
               eq_q_ff <= eq_mem[EW'(NW'(conn_q_ff)*MAX_DOF +
                                     (side_ff ? dcol_ff : drow_ff))];
               state_ff <= S_EQ;
            end
            S_EQ: begin
               if (!eq_good) bad_ff <= 1'b1;
               if (!side_ff) begin
                  er_ff <= eqv;
                  if (cmd_type'(cmd_ff) == CMD_ADD_STIFF) begin
                     side_ff <= 1'b1;
                     conn_q_ff <= conn_mem[CW'(elem_ff*MAX_NPE + scol_ff)];
                     state_ff <= S_CONN;
                  end else
                     state_ff <= S_EMIT;
               end else begin
                  ec_ff <= eqv;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               ok_ff   <= OP_NONE;
               osel_ff <= 2'd0;
               oaddr_ff <= '0;
               ost_ff  <= ST_BAD;
               case (cmd_type'(cmd_ff))
                  CMD_LOAD_CONN: begin
                     if (32'(elem_ff) < MAX_ELEMS && 32'(srow_ff) < MAX_NPE) ost_ff <= ST_BAD;
                  end
                  CMD_ADD_STIFF: begin
                     if (!bad_ff) begin
                        ok_ff <= OP_ACC;
                        osel_ff <= {er_ff < 0, ec_ff < 0};
                        oaddr_ff <= AW'({6'(er_ff < 0 ? -er_ff - 1 : er_ff - 1),
                                         6'(ec_ff < 0 ? -ec_ff - 1 : ec_ff - 1)});
                     end
                  end
                  CMD_ADD_LOAD: begin
                     // Vectors sit above the matrices in the store
                     if (!bad_ff) begin
                        ok_ff <= OP_ACC;
                        osel_ff <= {1'b0, er_ff < 0};
                        oaddr_ff <= AW'({1'b1, 6'd0,
                                         6'(er_ff < 0 ? -er_ff - 1 : er_ff - 1)});
                     end
                  end
                  CMD_READ_MAT: begin
                     if (32'(ri_ff) < ((blk_ff < 2) ? MAX_FREE : MAX_FIXED) &&
                         32'(ci_ff) < (blk_ff[0] ? MAX_FIXED : MAX_FREE)) begin
                        ok_ff <= OP_READ;
                        osel_ff <= blk_ff;
                        oaddr_ff <= AW'({ri_ff, ci_ff});
                     end
                  end
                  CMD_READ_VEC: begin
                     if ((blk_ff == 2'd0 && 32'(ri_ff) < MAX_FREE) ||
                         (blk_ff == 2'd1 && 32'(ri_ff) < MAX_FIXED)) begin
                        ok_ff <= OP_READ;
                        osel_ff <= {1'b0, blk_ff[0]};
                        oaddr_ff <= AW'({1'b1, 6'd0, ri_ff});
                     end
                  end
                  default: begin
                     ost_ff <= ST_BAD;
                  end
               endcase
               state_ff <= S_OUT;
               ov_ff <= 1'b1;
            end
            S_OUT: begin
               if (!op_stall) begin
                  ov_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic [2:0] stash_slot;
   logic [9:0] stash_node;
   logic [1:0] stash_dof;
   logic signed [7:0] stash_eq;
   always_ff @(posedge clock) begin
      if (accept) begin
         stash_slot <= node_slot; stash_node <= global_node;
         stash_dof <= node_dof; stash_eq <= equation;
      end
   end

   // Load commands are judged here; their status is ok when valid
   logic load_ok;
   assign load_ok = (cmd_type'(cmd_ff) == CMD_LOAD_CONN) ?
                       (32'(elem_ff) < MAX_ELEMS && 32'(stash_slot) < MAX_NPE &&
                        32'(stash_node) < MAX_NODES) :
                    (cmd_type'(cmd_ff) == CMD_LOAD_EQ) ?
                       (32'(stash_node) < MAX_NODES && 32'(stash_dof) < MAX_DOF &&
                        ((stash_eq > 0 && 32'(stash_eq) <= MAX_FREE) ||
                         (stash_eq < 0 && -32'(stash_eq) <= MAX_FIXED))) : 1'b0;

   assign op_valid  = ov_ff;
   assign op_kind   = ok_ff;
   assign op_sel    = osel_ff;
   assign op_addr   = oaddr_ff;
   assign op_value  = val_ff;
   assign op_status = load_ok ? ST_OK : ost_ff;

endmodule

// ===== sv/fss_back.sv =====
// Back part: matrix and vector store with saturating accumulate and reads.
// Depends on fss_pkg; store cleared by a sweep after reset.
module fss_back import fss_pkg::*; #(
   parameter int AW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          op_valid,
   output logic          op_stall,
   input  op_type        op_kind,
   input  logic [1:0]    op_sel,
   input  logic [AW-1:0] op_addr,
   input  logic [63:0]   op_value,
   input  logic [1:0]    op_status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_read_value,
   output logic [1:0]    rsp_status,
   output logic          busy_clear
);

   localparam int MW = AW + 2;
   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_RD, B_WR} state_type;

   logic [63:0] mem [2**MW];
   state_type   state_ff;
   logic [MW-1:0] clr_ff, addr_ff;
   logic [63:0] q_ff, v_ff;
   op_type      kind_ff;
   logic [1:0]  st_ff;
   logic        rv_ff;
   logic [63:0] rd_ff;
   logic [1:0]  rst_ff;
   logic [63:0] sum;
   logic        ovf;

   assign op_stall = (state_ff != B_IDLE) || (rv_ff && rsp_stall);
   assign sum = q_ff + v_ff;
   assign ovf = (q_ff[63] == v_ff[63]) && (sum[63] != q_ff[63]);

   always_ff @(posedge clock) begin
      if (state_ff == B_CLEAR) mem[clr_ff] <= '0;
      else if (state_ff == B_WR)
         mem[addr_ff] <= ovf ? (q_ff[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum;
      if (state_ff == B_IDLE) q_ff <= mem[{op_sel, op_addr}];
   end

   // Sweep, then one read or read-modify-write per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) state_ff <= B_IDLE;
            end
            B_IDLE: begin
               if (op_valid && !op_stall) begin
                  addr_ff <= {op_sel, op_addr};
                  v_ff <= op_value; kind_ff <= op_kind; st_ff <= op_status;
                  state_ff <= B_RD;
               end
            end
            B_RD: begin
               rv_ff <= 1'b1;
               rd_ff <= (kind_ff == OP_READ) ? q_ff : 64'd0;
               rst_ff <= (kind_ff == OP_NONE) ? st_ff :
                         (kind_ff == OP_ACC && ovf) ? ST_SAT : ST_OK;
               state_ff <= (kind_ff == OP_ACC) ? B_WR : B_IDLE;
            end
            B_WR: state_ff <= B_IDLE;
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_read_value = rd_ff;
   assign rsp_status     = rst_ff;
   assign busy_clear     = (state_ff == B_CLEAR);

endmodule

// ===== sv/fem_stiffness_scatter_add.sv =====
// Top level of the stiffness scatter-add block; joins front and back parts.
// Depends on fss_pkg, fss_front and fss_back.
// Table loads, reads and unused codes skip the table reads; a load entry
// first makes one connectivity and one equation read, and a stiffness entry
// makes one of each per index. The front can take the next item once its
// predecessor has passed to the back, before that result appears. A stalled
// result holds the back and, behind it, the front.
// After reset the back clears its 32768-entry store, one entry a cycle, and
// takes no item until done; the tables are undefined until loaded.
module fem_stiffness_scatter_add import fss_pkg::*; #(
   parameter int MAX_NODES_PER_ELEM = 8,
   parameter int MAX_DOF            = 3,
   parameter int MAX_ELEMS          = 1024,
   parameter int MAX_NODES          = 1024,
   parameter int MAX_FREE_EQ        = 64,
   parameter int MAX_FIXED_EQ       = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [3:0]   csr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_command,
   input  logic [9:0]   req_element,
   input  logic [4:0]   req_local_row,
   input  logic [4:0]   req_local_col,
   input  logic [2:0]   req_node_slot,
   input  logic [9:0]   req_global_node,
   input  logic [1:0]   req_node_dof,
   input  logic signed [7:0] req_equation,
   input  logic signed [63:0] req_value,
   input  logic [1:0]   req_block_select,
   input  logic [5:0]   req_row_index,
   input  logic [5:0]   req_col_index,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic signed [63:0] rsp_read_value,
   output logic [1:0]   rsp_status
);

   localparam int AW = 13;

   logic [1:0] dof_ff;
   logic [3:0] npe_ff;
   logic       f_stall, op_valid, op_stall, busy;
   op_type     op_kind;
   logic [1:0] op_sel, op_status;
   logic [AW-1:0] op_addr;
   logic [63:0] op_value, rdv;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dof_ff <= 2'd3;
         npe_ff <= 4'd8;
      end else if (csr_write) begin
         if (csr_index == REG_DOF) dof_ff <= csr_data[1:0];
         if (csr_index == REG_NPE) npe_ff <= csr_data;
      end
   end

   assign req_stall = f_stall || busy;

   fss_front #(
      .MAX_NPE(MAX_NODES_PER_ELEM), .MAX_DOF(MAX_DOF), .MAX_ELEMS(MAX_ELEMS),
      .MAX_NODES(MAX_NODES), .MAX_FREE(MAX_FREE_EQ), .MAX_FIXED(MAX_FIXED_EQ),
      .AW(AW)
   ) u_front (
      .clock, .reset, .dof_per_node(dof_ff), .nodes_per_element(npe_ff),
      .in_valid(req_valid && !busy), .in_stall(f_stall),
      .command(req_command), .element(req_element), .local_row(req_local_row),
      .local_col(req_local_col), .node_slot(req_node_slot),
      .global_node(req_global_node), .node_dof(req_node_dof),
      .equation(req_equation), .value(req_value),
      .block_select(req_block_select), .row_index(req_row_index),
      .col_index(req_col_index), .op_valid, .op_stall, .op_kind, .op_sel,
      .op_addr, .op_value, .op_status
   );

   fss_back #(.AW(AW)) u_back (
      .clock, .reset, .op_valid, .op_stall, .op_kind, .op_sel, .op_addr,
      .op_value, .op_status, .rsp_valid, .rsp_stall, .rsp_read_value(rdv),
      .rsp_status, .busy_clear(busy)
   );

   assign rsp_read_value = rdv;

`ifndef SYNTH
   // No item enters during the clearing sweep
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("item accepted during clear");
   // A saturated status never comes with read data
   a_sat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |-> (rsp_read_value == 64'd0))
      else $error("saturation with read data");
   // A bad status never comes with read data
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD) |-> (rsp_read_value == 64'd0))
      else $error("bad status with read data");
`endif

endmodule

// ===== tb/sv/fem_stiffness_scatter_add_check.sv =====
// Checker for the stiffness scatter-add block: watches the register port and
// both item channels, predicts each result and compares it with the block.
// Depends on fss_pkg.
module fem_stiffness_scatter_add_check import fss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [9:0]         req_element,
   input  logic [4:0]         req_local_row,
   input  logic [4:0]         req_local_col,
   input  logic [2:0]         req_node_slot,
   input  logic [9:0]         req_global_node,
   input  logic [1:0]         req_node_dof,
   input  logic signed [7:0]  req_equation,
   input  logic signed [63:0] req_value,
   input  logic [1:0]         req_block_select,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [63:0] rsp_read_value,
   input  logic [1:0]         rsp_status,
   output int                 failures,
   output int                 pending
);

   // Partition codes for the matrix store
   localparam int BLK_FF = 0, BLK_FX = 1, BLK_XF = 2, BLK_XX = 3;

   logic [9:0]  node_of_slot [8192];
   int          eq_of_dof [3072];
   logic [63:0] stiff_sum [4][4096];
   logic [63:0] load_sum [2][64];
   logic [1:0]  dofs;
   logic [3:0]  npe;
   logic [63:0] want_value [$];
   logic [1:0]  want_status [$];

   assign pending = want_value.size();

   function automatic bit eq_valid(input int e);
      if (e > 0) return e <= 64;
      if (e < 0) return -e <= 64;
      return 0;
   endfunction

   // Map element and local dof index to an equation number
   function automatic bit map_equation(input int el, input int loc, output int e);
      int slot, d, node;
      e = 0;
      if (loc >= int'(npe) * int'(dofs)) return 0;
      slot = loc / dofs;
      d    = loc % dofs;
      node = node_of_slot[el * 8 + slot];
      e    = eq_of_dof[node * 3 + d];
      return eq_valid(e);
   endfunction

   // Saturating signed add; returns the status of the sum
   function automatic logic [1:0] sum_sat(input logic [63:0] a, input logic [63:0] v,
                                          output logic [63:0] s);
      s = a + v;
      if (((a ^ s) & (v ^ s)) >> 63) begin
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         return ST_SAT;
      end
      return ST_OK;
   endfunction

   task automatic predict_result();
      logic [63:0] rd, s;
      logic [1:0]  st;
      int          er, ec, b, k;
      bit          regs_ok;
      rd = '0;
      st = ST_BAD;
      regs_ok = dofs >= 1 && dofs <= 3 && npe >= 1 && npe <= 8;
      case (req_command)
         CMD_LOAD_CONN: begin
            node_of_slot[req_element * 8 + req_node_slot] = req_global_node;
            st = ST_OK;
         end
         CMD_LOAD_EQ: begin
            if (req_node_dof < 3 && eq_valid(int'(req_equation))) begin
               eq_of_dof[req_global_node * 3 + req_node_dof] = int'(req_equation);
               st = ST_OK;
            end
         end
         CMD_ADD_STIFF: begin
            if (regs_ok && map_equation(req_element, req_local_row, er) &&
                map_equation(req_element, req_local_col, ec)) begin
               if (er > 0 && ec > 0) b = BLK_FF;
               else if (er > 0) b = BLK_FX;
               else if (ec > 0) b = BLK_XF;
               else b = BLK_XX;
               k = ((er > 0 ? er : -er) - 1) * 64 + (ec > 0 ? ec : -ec) - 1;
               st = sum_sat(stiff_sum[b][k], req_value, s);
               stiff_sum[b][k] = s;
            end
         end
         CMD_ADD_LOAD: begin
            if (regs_ok && map_equation(req_element, req_local_row, er)) begin
               b = er > 0 ? 0 : 1;
               k = (er > 0 ? er : -er) - 1;
               st = sum_sat(load_sum[b][k], req_value, s);
               load_sum[b][k] = s;
            end
         end
         CMD_READ_MAT: begin
            rd = stiff_sum[req_block_select][req_row_index * 64 + req_col_index];
            st = ST_OK;
         end
         CMD_READ_VEC: begin
            if (req_block_select < 2) begin
               rd = load_sum[req_block_select][req_row_index];
               st = ST_OK;
            end
         end
         default: ;
      endcase
      want_value.push_back(rd);
      want_status.push_back(st);
   endtask

   // Track registers, predict accepted items, compare results
   always @(posedge clock) begin
      if (reset) begin
         dofs = 2'd3;
         npe  = 4'd8;
         foreach (stiff_sum[b, k]) stiff_sum[b][k] = '0;
         foreach (load_sum[b, k]) load_sum[b][k] = '0;
         want_value.delete();
         want_status.delete();
         failures = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_DOF) dofs = csr_data[1:0];
            else if (csr_index == REG_NPE) npe = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (want_value.size() == 0) begin
               $error("result with no item outstanding");
               failures++;
            end else begin
               if (rsp_read_value !== want_value[0]) begin
                  $error("read_value: expected %h, got %h", want_value[0], rsp_read_value);
                  failures++;
               end
               if (rsp_status !== want_status[0]) begin
                  $error("status: expected %0d, got %0d", want_status[0], rsp_status);
                  failures++;
               end
               void'(want_value.pop_front());
               void'(want_status.pop_front());
            end
         end
         if (req_valid && !req_stall) predict_result();
      end
   end

endmodule

// ===== tb/sv/fem_stiffness_scatter_add_test.sv =====
// Testbench top for the stiffness scatter-add block: makes stimulus and
// gives the verdict. Depends on fss_pkg, the block and its checker.
module fem_stiffness_scatter_add_test;
   import fss_pkg::*;

   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam int         IDLE_LIMIT  = 200000;
   localparam int         SETTLE      = 16;

   logic clock, reset;
   logic csr_write;
   logic [1:0] csr_index;
   logic [3:0] csr_data;
   logic req_valid, req_stall;
   logic [2:0] req_command;
   logic [9:0] req_element;
   logic [4:0] req_local_row, req_local_col;
   logic [2:0] req_node_slot;
   logic [9:0] req_global_node;
   logic [1:0] req_node_dof;
   logic signed [7:0]  req_equation;
   logic signed [63:0] req_value;
   logic [1:0] req_block_select;
   logic [5:0] req_row_index, req_col_index;
   logic rsp_valid, rsp_stall;
   logic signed [63:0] rsp_read_value;
   logic [1:0] rsp_status;
   int failures, pending, idle_cycles, burst_left, stall_mode, stall_left;

   typedef struct {
      logic [2:0] command;
      logic [9:0] element;
      logic [4:0] local_row, local_col;
      logic [2:0] node_slot;
      logic [9:0] global_node;
      logic [1:0] node_dof;
      logic [7:0] equation;
      logic [63:0] value;
      logic [1:0] block_select;
      logic [5:0] row_index, col_index;
   } entry_type;

   fem_stiffness_scatter_add u_dut (.*);
   fem_stiffness_scatter_add_check u_check (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver stall: switch between free, light and heavy stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic entry_type noise();
      entry_type e;
      e.command = 3'($urandom); e.element = 10'($urandom);
      e.local_row = 5'($urandom); e.local_col = 5'($urandom);
      e.node_slot = 3'($urandom); e.global_node = 10'($urandom);
      e.node_dof = 2'($urandom); e.equation = 8'($urandom);
      e.value = {$urandom, $urandom};
      e.block_select = 2'($urandom); e.row_index = 6'($urandom);
      e.col_index = 6'($urandom);
      return e;
   endfunction

   // Hold the item until accepted; bursts with random gaps between them
   task automatic send(input entry_type e);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= e.command; req_element <= e.element;
      req_local_row <= e.local_row; req_local_col <= e.local_col;
      req_node_slot <= e.node_slot; req_global_node <= e.global_node;
      req_node_dof <= e.node_dof; req_equation <= e.equation; req_value <= e.value;
      req_block_select <= e.block_select; req_row_index <= e.row_index;
      req_col_index <= e.col_index;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 64'h7FFF_FFFF_FFFF_FFFF;
         1: return 64'h8000_0000_0000_0000;
         2: return {$urandom, $urandom};
         default: return {{32{1'b0}}, $urandom} - 64'h8000_0000;
      endcase
   endfunction

   // Random item mix: table users only touch loaded elements
   function automatic entry_type random_entry();
      entry_type e;
      int r;
      e = noise();
      r = $urandom_range(0, 99);
      if (r < 45) e.command = CMD_ADD_STIFF;
      else if (r < 60) e.command = CMD_ADD_LOAD;
      else if (r < 75) e.command = CMD_READ_MAT;
      else if (r < 83) e.command = CMD_READ_VEC;
      else if (r < 89) e.command = CMD_LOAD_CONN;
      else if (r < 95) e.command = CMD_LOAD_EQ;
      else e.command = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
      if (e.command inside {CMD_ADD_STIFF, CMD_ADD_LOAD}) begin
         e.element = 10'($urandom_range(0, 3));
         if ($urandom_range(0, 7) != 0) begin
            e.local_row = 5'($urandom_range(0, 23));
            e.local_col = 5'($urandom_range(0, 23));
         end
         e.value = pick_value();
      end
      if (e.command == CMD_LOAD_CONN && e.element < 4)
         e.global_node = 10'($urandom_range(0, 15));
      if (e.command == CMD_READ_MAT || e.command == CMD_READ_VEC) begin
         e.row_index = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7));
         e.col_index = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7));
      end
      return e;
   endfunction

   initial begin
      entry_type e;
      logic [3:0] dof_set [8];
      logic [3:0] npe_set [8];
      reset = 1'b1;
      csr_write = 1'b0; csr_index = REG_DOF; csr_data = '0;
      req_valid = 1'b0;
      e = noise();
      {req_command, req_element, req_local_row, req_local_col, req_node_slot,
       req_global_node, req_node_dof, req_equation, req_value, req_block_select,
       req_row_index, req_col_index} = '0;
      rsp_stall = 1'b0; stall_mode = 0; stall_left = 0;
      idle_cycles = 0; burst_left = 0;
      dof_set = '{4'd3, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd2, 4'd15};
      npe_set = '{4'd8, 4'd1, 4'd5, 4'd8, 4'd0, 4'd15, 4'd8, 4'd8};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Load connectivity of elements 0..3 and equations of nodes 0..15
      for (int el = 0; el < 4; el++)
         for (int s = 0; s < 8; s++) begin
            e = noise(); e.command = CMD_LOAD_CONN; e.element = 10'(el);
            e.node_slot = 3'(s); e.global_node = 10'($urandom_range(0, 15));
            send(e);
         end
      for (int n = 0; n < 16; n++)
         for (int d = 0; d < 3; d++) begin
            e = noise(); e.command = CMD_LOAD_EQ; e.global_node = 10'(n);
            e.node_dof = 2'(d);
            case ((n * 3 + d) % 6)
               0: e.equation = 8'sd64;
               1: e.equation = -8'sd64;
               2: e.equation = 8'sd1;
               3: e.equation = -8'sd1;
               default: e.equation = 8'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                             : -$urandom_range(1, 64));
            endcase
            send(e);
         end

      // Directed corners: bad equations, saturation, bad reads, spare codes
      e = noise(); e.command = CMD_LOAD_EQ; e.node_dof = 0; e.equation = 0; send(e);
      e.equation = 8'sd65; send(e);
      e.equation = -8'sd65; send(e);
      e.equation = 8'h80; send(e);
      e.equation = 8'sd127; send(e);
      e.equation = 8'sd5; e.node_dof = 3; send(e);
      e = noise(); e.command = CMD_LOAD_CONN; e.element = 10'd1023; e.node_slot = 7;
      e.global_node = 10'd1023; send(e);
      for (int k = 0; k < 3; k++) begin
         e = noise(); e.command = CMD_ADD_STIFF; e.element = 0;
         e.local_row = 0; e.local_col = 23; e.value = 64'h7FFF_FFFF_FFFF_FFFF; send(e);
         e.value = 64'h8000_0000_0000_0000; e.local_col = 1; send(e);
      end
      e = noise(); e.command = CMD_ADD_STIFF; e.element = 1; e.local_row = 24; send(e);
      e.local_row = 31; e.local_col = 31; send(e);
      e = noise(); e.command = CMD_ADD_LOAD; e.element = 2; e.local_row = 23;
      e.value = 64'h7FFF_FFFF_FFFF_FFFF; send(e); send(e);
      for (int b = 0; b < 4; b++) begin
         e = noise(); e.command = CMD_READ_MAT; e.block_select = 2'(b);
         e.row_index = b == 0 ? 6'd63 : 6'd0; e.col_index = b == 0 ? 6'd0 : 6'd63;
         send(e);
         e.command = CMD_READ_VEC; send(e);
      end
      e = noise(); e.command = CMD_SPARE_A; send(e);
      e.command = CMD_SPARE_B; send(e);

      // Random phases across register settings
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_DOF, dof_set[p]);
         write_reg(REG_NPE, npe_set[p]);
         repeat (40) send(random_entry());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
